[rtl/text_page_cell_layout_unit_defines.svh]
// Assertion macros shared by the layout unit RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef TEXT_PAGE_CELL_LAYOUT_UNIT_DEFINES_SVH
`define TEXT_PAGE_CELL_LAYOUT_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on clk, off during reset
`define TPCL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define TPCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TPCL_ASSERT_IMPL(lbl, ante, cons, msg)
`define TPCL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/tpcl_pkg.sv]
`default_nettype none

package tpcl_pkg;

    // Page geometry
    localparam int COLUMNS = 16;
    localparam int ROWS    = 2;
    localparam int COL_W   = 4;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic             ROW_LAST = 1'(ROWS - 1);

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_LF,
        KIND_NUL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
    } cmd_t;

    typedef struct packed {
        logic has_room;
        logic has_data;
    } queue_stat_t;

endpackage

`default_nettype wire

[rtl/text_page_cell_layout_unit.sv]
`default_nettype none

// Text page layout: takes one text byte per transaction and produces display cells for a
// two-row page of 16 columns, each cell tagged with row, column, page_end and run_last.
// Carriage return is accepted but yields no cell; a line feed yields 1 to 16 padding
// cells and a zero byte 1 to 32. The back-end cell sequencer produces one cell per
// cycle while the command queue holds data and the result side pops every cycle; a
// printable byte makes one cell. A byte passes through the front register and the
// four-entry command queue before the output register holds its first cell. The queue
// lets input continue while a long padding run is being drained.
module text_page_cell_layout_unit (
    input  wire  logic       clk,
    input  wire  logic       rst_n,
    input  wire  logic       push,
    output logic             full,
    input  wire  logic [7:0] text_byte,
    output logic             empty,
    input  wire  logic       pop,
    output logic [7:0]       cell_char,
    output logic             cell_row,
    output logic [3:0]       cell_column,
    output logic             page_end,
    output logic             run_last
);

    tpcl_pkg::queue_stat_t q_stat;
    tpcl_pkg::cmd_t        q_wdata;
    tpcl_pkg::cmd_t        q_rdata;
    logic                  q_write;
    logic                  q_read;

    // Accept and classify bytes
    tpcl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .text_byte (text_byte),
        .full      (full),
        .q_stat    (q_stat),
        .q_write   (q_write),
        .q_wdata   (q_wdata)
    );

    // Buffer commands between front and back
    tpcl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_write (q_write),
        .q_wdata (q_wdata),
        .q_read  (q_read),
        .q_rdata (q_rdata),
        .q_stat  (q_stat)
    );

    // Sequence cells onto the page
    tpcl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_rdata     (q_rdata),
        .q_read      (q_read),
        .pop         (pop),
        .empty       (empty),
        .cell_char   (cell_char),
        .cell_row    (cell_row),
        .cell_column (cell_column),
        .page_end    (page_end),
        .run_last    (run_last)
    );

endmodule

`default_nettype wire

[rtl/tpcl_front.sv]
`default_nettype none

module tpcl_front (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic push,
    input  wire                logic [7:0] text_byte,
    output logic               full,
    input  tpcl_pkg::queue_stat_t q_stat,
    output logic               q_write,
    output tpcl_pkg::cmd_t     q_wdata
);

    logic           cmd_valid_reg;
    logic           cmd_valid_next;
    tpcl_pkg::cmd_t cmd_reg;
    tpcl_pkg::cmd_t cmd_next;
    logic           accept;

    // Stall input while the held command cannot enter the queue
    assign full    = cmd_valid_reg && !q_stat.has_room;
    assign accept  = push && !full;
    assign q_write = cmd_valid_reg && q_stat.has_room;
    assign q_wdata = cmd_reg;

    // Classify the incoming byte; drop carriage return
    always_comb
    begin
        cmd_next.ch = text_byte;
        case (text_byte)
            tpcl_pkg::CH_LF:  cmd_next.kind = tpcl_pkg::KIND_LF;
            tpcl_pkg::CH_NUL: cmd_next.kind = tpcl_pkg::KIND_NUL;
            default:          cmd_next.kind = tpcl_pkg::KIND_CHAR;
        endcase

        cmd_valid_next = cmd_valid_reg;
        if (accept)
        begin
            cmd_valid_next = (text_byte != tpcl_pkg::CH_CR);
        end
        else if (q_write)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    // Hold the command payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tpcl_queue.sv]
`default_nettype none
`include "text_page_cell_layout_unit_defines.svh"

module tpcl_queue (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic q_write,
    input  tpcl_pkg::cmd_t     q_wdata,
    input  wire                logic q_read,
    output tpcl_pkg::cmd_t     q_rdata,
    output tpcl_pkg::queue_stat_t q_stat
);

    tpcl_pkg::cmd_t                   entry_reg [tpcl_pkg::QUEUE_DEPTH];
    logic [tpcl_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [tpcl_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [tpcl_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [tpcl_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [tpcl_pkg::QCNT_W-1:0]      count_reg;
    logic [tpcl_pkg::QCNT_W-1:0]      count_next;

    assign q_stat.has_room = (count_reg != tpcl_pkg::QCNT_W'(tpcl_pkg::QUEUE_DEPTH));
    assign q_stat.has_data = (count_reg != '0);
    assign q_rdata         = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_write)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_read)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({q_write, q_read})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (q_write)
        begin
            entry_reg[wr_ptr_reg] <= q_wdata;
        end
    end

    `TPCL_ASSERT_IMPL(a_no_read_empty, q_read, q_stat.has_data, "queue read while empty")
    `TPCL_ASSERT_IMPL(a_no_write_full, q_write, q_stat.has_room, "queue write while full")
    `TPCL_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= tpcl_pkg::QCNT_W'(tpcl_pkg::QUEUE_DEPTH), "queue count overflow")

endmodule

`default_nettype wire

[rtl/tpcl_back.sv]
`default_nettype none
`include "text_page_cell_layout_unit_defines.svh"

module tpcl_back (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  tpcl_pkg::queue_stat_t q_stat,
    input  tpcl_pkg::cmd_t     q_rdata,
    output logic               q_read,
    input  wire                logic pop,
    output logic               empty,
    output logic [7:0]         cell_char,
    output logic               cell_row,
    output logic [3:0]         cell_column,
    output logic               page_end,
    output logic               run_last
);

    logic [tpcl_pkg::COL_W-1:0] col_reg;
    logic [tpcl_pkg::COL_W-1:0] col_next;
    logic                       row_reg;
    logic                       row_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [7:0]                 char_reg;
    logic                       row_out_reg;
    logic [tpcl_pkg::COL_W-1:0] col_out_reg;
    logic                       pe_reg;
    logic                       last_reg;
    logic                       emit;
    logic                       col_last;
    logic                       row_last;
    logic                       pe_now;
    logic                       last_now;
    logic [7:0]                 char_now;

    // Emit one cell when the output slot is free or being drained
    assign emit     = q_stat.has_data && (!out_valid_reg || pop);
    assign col_last = (col_reg == tpcl_pkg::COL_LAST);
    assign row_last = (row_reg == tpcl_pkg::ROW_LAST);
    assign pe_now   = col_last && row_last;
    assign q_read   = emit && last_now;

    // Decide the cell content and whether it ends this command
    always_comb
    begin
        char_now = tpcl_pkg::CH_SPACE;
        last_now = 1'b0;
        case (q_rdata.kind)
            tpcl_pkg::KIND_CHAR:
            begin
                char_now = q_rdata.ch;
                last_now = 1'b1;
            end
            tpcl_pkg::KIND_LF:  last_now = col_last;
            tpcl_pkg::KIND_NUL: last_now = pe_now;
            default:            last_now = 1'b1;
        endcase
    end

    // Advance the page position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (emit)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? 1'b0 : 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output register with the new cell
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            char_reg    <= char_now;
            row_out_reg <= row_reg;
            col_out_reg <= col_reg;
            pe_reg      <= pe_now;
            last_reg    <= last_now;
        end
    end

    assign empty       = !out_valid_reg;
    assign cell_char   = char_reg;
    assign cell_row    = row_out_reg;
    assign cell_column = col_out_reg;
    assign page_end    = pe_reg;
    assign run_last    = last_reg;

    `TPCL_ASSERT_NEXT(a_page_home, emit && pe_now, (col_reg == '0) && (row_reg == 1'b0), "position not home after page end")
    `TPCL_ASSERT_IMPL(a_col_range, 1'b1, col_reg <= tpcl_pkg::COL_LAST, "column beyond row width")
    `TPCL_ASSERT_IMPL(a_page_end_last, out_valid_reg && pe_reg, last_reg, "page end cell does not close its run")

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int ITEMS_PER_RUN = 114;
    localparam int DRAIN_CYCLES  = 40;

    // Opening sequence: blank page, row pads, bottom-row break, byte extremes
    localparam logic [7:0] OPENING_BYTES [18] = '{
        tpcl_pkg::CH_NUL, tpcl_pkg::CH_LF, tpcl_pkg::CH_LF, 8'h48, 8'h69,
        tpcl_pkg::CH_CR, tpcl_pkg::CH_LF, 8'h78, tpcl_pkg::CH_LF,
        tpcl_pkg::CH_CR, 8'hFF, 8'h80, 8'h01, 8'h7F, tpcl_pkg::CH_SPACE,
        tpcl_pkg::CH_NUL, tpcl_pkg::CH_LF, 8'hFE
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       row;
        logic [3:0] column;
        logic       page_end;
        logic       run_last;
    } display_cell_t;

    // Track the page cursor and hold the cells each accepted byte should produce
    class page_layout_scoreboard;
        display_cell_t pending_cells[$];
        logic          cursor_row;
        logic [3:0]    cursor_column;
        int            errors;

        function new();
            cursor_row    = 1'b0;
            cursor_column = '0;
            errors        = 0;
        endfunction

        // Queue one cell at the cursor and advance; return 1 when the page completes
        function bit place_cell(logic [7:0] ch);
            display_cell_t slot;
            slot.ch       = ch;
            slot.row      = cursor_row;
            slot.column   = cursor_column;
            slot.page_end = 1'b0;
            slot.run_last = 1'b0;
            if (int'(cursor_column) == tpcl_pkg::COLUMNS - 1)
            begin
                cursor_column = '0;
                if (int'(cursor_row) == tpcl_pkg::ROWS - 1)
                begin
                    cursor_row    = 1'b0;
                    slot.page_end = 1'b1;
                end
                else
                begin
                    cursor_row = cursor_row + 1'b1;
                end
            end
            else
            begin
                cursor_column = cursor_column + 1'b1;
            end
            pending_cells.push_back(slot);
            return slot.page_end;
        endfunction

        function void note_byte(logic [7:0] b);
            logic start_row;
            bit   done;
            if (b == tpcl_pkg::CH_CR)
                return;
            if (b == tpcl_pkg::CH_LF)
            begin
                start_row = cursor_row;
                do
                    done = place_cell(tpcl_pkg::CH_SPACE);
                while (!done && cursor_row == start_row);
            end
            else if (b == tpcl_pkg::CH_NUL)
            begin
                do
                    done = place_cell(tpcl_pkg::CH_SPACE);
                while (!done);
            end
            else
            begin
                done = place_cell(b);
            end
            pending_cells[pending_cells.size() - 1].run_last = 1'b1;
        endfunction

        function void check_cell(display_cell_t got);
            display_cell_t want;
            if (pending_cells.size() == 0)
            begin
                $error("unexpected cell: char %0d row %0d column %0d",
                       got.ch, got.row, got.column);
                errors++;
                return;
            end
            want = pending_cells.pop_front();
            if (got.ch !== want.ch)
            begin
                $error("cell_char: expected %0d, actual %0d", want.ch, got.ch);
                errors++;
            end
            if (got.row !== want.row)
            begin
                $error("cell_row: expected %0d, actual %0d", want.row, got.row);
                errors++;
            end
            if (got.column !== want.column)
            begin
                $error("cell_column: expected %0d, actual %0d", want.column, got.column);
                errors++;
            end
            if (got.page_end !== want.page_end)
            begin
                $error("page_end: expected %0d, actual %0d", want.page_end, got.page_end);
                errors++;
            end
            if (got.run_last !== want.run_last)
            begin
                $error("run_last: expected %0d, actual %0d", want.run_last, got.run_last);
                errors++;
            end
        endfunction

        function int pending_count();
            return pending_cells.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] text_byte;
    logic       empty;
    logic       pop;
    logic [7:0] cell_char;
    logic       cell_row;
    logic [3:0] cell_column;
    logic       page_end;
    logic       run_last;

    int send_idle;
    int recv_idle;
    int cycles;

    page_layout_scoreboard layout_sb;

    text_page_cell_layout_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .empty       (empty),
        .pop         (pop),
        .cell_char   (cell_char),
        .cell_row    (cell_row),
        .cell_column (cell_column),
        .page_end    (page_end),
        .run_last    (run_last)
    );

    // Generate the clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Drive pop with random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= recv_idle);
    end

    // Check each popped cell transaction
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            layout_sb.check_cell('{cell_char, cell_row, cell_column, page_end, run_last});
    end

    // Push one byte; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        text_byte <= b;
        do
            @(posedge clk);
        while (full);
        layout_sb.note_byte(b);
        @(negedge clk);
    endtask

    // Mostly printable text with line breaks, some carriage returns and ends of text
    function automatic logic [7:0] random_text_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 68)
            return 8'($urandom_range(8'h7E, 8'h21));
        else if (pick < 72)
            return tpcl_pkg::CH_SPACE;
        else if (pick < 82)
            return tpcl_pkg::CH_LF;
        else if (pick < 87)
            return tpcl_pkg::CH_CR;
        else if (pick < 90)
            return tpcl_pkg::CH_NUL;
        else
            return 8'($urandom_range(255));
    endfunction

    initial
    begin
        logic [7:0] b;
        int         sent;
        cycles    = 0;
        send_idle = 17;
        recv_idle = 80;
        rst_n     = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        text_byte = '0;
        layout_sb = new();

        // Hold reset, then release away from the rising edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (OPENING_BYTES[i])
            send_byte(OPENING_BYTES[i]);

        // Three idling runs: slow receiver, slow sender, then full rate
        for (int run = 0; run < 3; run++)
        begin
            send_idle = (run == 0) ? 17 : (run == 1) ? 80 : 0;
            recv_idle = (run == 0) ? 80 : (run == 1) ? 17 : 0;
            sent = 0;
            while (sent < ITEMS_PER_RUN)
            begin
                b = random_text_byte();
                send_byte(b);
                sent++;
            end
        end
        push <= 1'b0;

        // Drain outstanding cells, then watch for strays
        while (layout_sb.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (layout_sb.errors == 0 && layout_sb.pending_count() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
